>>> rtl/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;

    localparam int MAX_SETS_DEF  = 64;
    localparam int MAX_WAYS_DEF  = 8;
    localparam int ADDR_BITS_DEF = 32;

    localparam int TAG_W    = 32;
    localparam int AGE_W    = 8;
    localparam int SETIDX_W = 6;
    localparam int OFF_W    = 6;
    localparam int MREF_W   = 2;
    localparam int SIZE_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

    localparam logic [MREF_W-1:0] MREF_HIT   = 2'd0;
    localparam logic [MREF_W-1:0] MREF_FILL  = 2'd1;
    localparam logic [MREF_W-1:0] MREF_WBACK = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the request into the datapath registers
        logic update;    // write back the looked-up set
        logic load_out;  // load the result register
    } salc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_access;
    } salc_sts_t;

endpackage

>>> rtl/salc_if.sv
`timescale 1ns / 1ps
interface salc_req_if;
    import salc_pkg::*;
    logic               valid;
    logic               ready;
    logic               is_write;
    logic [SIZE_W-1:0]  size_bytes;
    logic [31:0]        address;
    modport source (output valid, is_write, size_bytes, address, input ready);
    modport sink   (input valid, is_write, size_bytes, address, output ready);
endinterface

interface salc_rsp_if;
    import salc_pkg::*;
    logic                valid;
    logic                ready;
    logic                error;
    logic                hit;
    logic [TAG_W-1:0]    tag;
    logic [SETIDX_W-1:0] set_index;
    logic [OFF_W-1:0]    line_offset;
    logic [MREF_W-1:0]   memrefs;
    modport source (output valid, error, hit, tag, set_index, line_offset, memrefs,
                    input ready);
    modport sink   (input valid, error, hit, tag, set_index, line_offset, memrefs,
                    output ready);
endinterface

>>> rtl/set_assoc_lru_writeback_cache_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req       in         is_write, size_bytes, address
// rsp       out        error, hit, tag, set_index, line_offset, memrefs
// cfg       in         cfg_we, cfg_index, cfg_data (set_bits, ways_in_use, line_bits)
//
// Each request runs in two steps: the first splits the address and reads the set row,
// the second compares tags, picks the victim and, unless the access is bad, writes the row back.
// The row memory has one read and one write port.
// A request is taken while an earlier result still waits in the output register.
// Reset needs no clearing pass; a valid bit per set row marks rows never written.
// A stall on rsp holds the lookup step until the output register is free.
module set_assoc_lru_writeback_cache_core
    import salc_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    salc_req_if.sink             req,
    salc_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Geometry registers; the cache is not flushed when they change.
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [2:0] line_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg  <= 3'd4;
            ways_reg      <= 4'd2;
            line_bits_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_BITS:  set_bits_reg  <= cfg_data[2:0];
                REG_WAYS:      ways_reg      <= cfg_data;
                REG_LINE_BITS: line_bits_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    salc_cmd_t cmd;
    salc_sts_t sts;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    salc_dp #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .set_bits        (set_bits_reg),
        .ways_in_use     (ways_reg),
        .line_bits       (line_bits_reg),
        .in_is_write     (req.is_write),
        .in_size         (req.size_bytes),
        .in_address      (req.address),
        .out_error       (rsp.error),
        .out_hit         (rsp.hit),
        .out_tag         (rsp.tag),
        .out_set_index   (rsp.set_index),
        .out_line_offset (rsp.line_offset),
        .out_memrefs     (rsp.memrefs)
    );

endmodule

>>> rtl/salc_ctrl.sv
`timescale 1ns / 1ps
module salc_ctrl
    import salc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  salc_sts_t sts,
    output salc_cmd_t cmd
);

    typedef enum logic [0:0] {ST_IDLE, ST_LOOKUP} state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // Lookup finishes once the output register is free or being drained; a new request is taken whenever idle.
    logic out_free;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    cmd.update     = !sts.bad_access;
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("capture did not enter lookup");
    a_update_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> cmd.load_out)
        else $error("set updated without a result");
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp_valid_reg)
        else $error("result lost");

endmodule

>>> rtl/salc_dp.sv
`timescale 1ns / 1ps
module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  salc_cmd_t            cmd,
    output salc_sts_t            sts,
    input  logic [2:0]           set_bits,
    input  logic [3:0]           ways_in_use,
    input  logic [2:0]           line_bits,
    input  logic                 in_is_write,
    input  logic [SIZE_W-1:0]    in_size,
    input  logic [31:0]          in_address,
    output logic                 out_error,
    output logic                 out_hit,
    output logic [TAG_W-1:0]     out_tag,
    output logic [SETIDX_W-1:0]  out_set_index,
    output logic [OFF_W-1:0]     out_line_offset,
    output logic [MREF_W-1:0]    out_memrefs
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    // Largest set_bits whose set count still fits in MAX_SETS.
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int ROW_W  = MAX_WAYS * (1 + TAG_W + 1 + AGE_W);

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } way_t;

    // One row per set, holding every way; a row-valid bit stands for the reset.
    way_t [MAX_WAYS-1:0] mem [MAX_SETS];
    logic [MAX_SETS-1:0] row_ok_reg;
    way_t [MAX_WAYS-1:0] row_rd_reg;
    logic                row_ok_rd_reg;

    logic             wr_reg;
    logic             bad_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;
    logic [OFF_W-1:0] off_reg;
    logic [WCNT_W-1:0] ways_reg;

    // Address split in the capture cycle.
    logic [63:0]      addr;
    logic             bad;
    logic [2:0]       sb, lb;
    logic [3:0]       lsb_sum;
    logic [63:0]      tag_c, set_c, off_c;
    logic [WCNT_W-1:0] ways_c;

    always_comb
    begin
        addr = {32'd0, in_address};
        if (ADDR_BITS < 64)
            addr = addr & ((64'd1 << ADDR_BITS) - 64'd1);
        bad = !(in_size inside {4'd1, 4'd2, 4'd4, 4'd8}) ||
              ((addr[3:0] & (in_size - 4'd1)) != 4'd0);
        sb = (int'(set_bits) > SB_MAX) ? 3'(SB_MAX) : set_bits;
        lb = (line_bits > 3'd6) ? 3'd6 : line_bits;
        lsb_sum = {1'b0, sb} + {1'b0, lb};
        tag_c = addr >> lsb_sum;
        set_c = (addr >> lb) & ((64'd1 << sb) - 64'd1);
        off_c = addr & ((64'd1 << lb) - 64'd1);
        if (ways_in_use == 4'd0)
            ways_c = WCNT_W'(1);
        else if (int'(ways_in_use) > MAX_WAYS)
            ways_c = WCNT_W'(MAX_WAYS);
        else
            ways_c = WCNT_W'(ways_in_use);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            wr_reg        <= in_is_write;
            bad_reg       <= bad;
            tag_reg       <= tag_c[TAG_W-1:0];
            set_reg       <= set_c[SET_W-1:0];
            off_reg       <= off_c[OFF_W-1:0];
            ways_reg      <= ways_c;
            row_rd_reg    <= mem[set_c[SET_W-1:0]];
            row_ok_rd_reg <= row_ok_reg[set_c[SET_W-1:0]];
        end
    end

    assign sts.bad_access = bad_reg;

    // Lookup, LRU and victim choice over the registered row.
    way_t [MAX_WAYS-1:0] row;
    way_t [MAX_WAYS-1:0] row_new;
    logic                hit;
    logic [WAY_W-1:0]    hit_w, inv_w, old_w, vic_w;
    logic                inv_found;
    logic [MREF_W-1:0]   mref;

    always_comb
    begin
        row       = row_ok_rd_reg ? row_rd_reg : '0;
        hit       = 1'b0;
        hit_w     = '0;
        inv_found = 1'b0;
        inv_w     = '0;
        old_w     = '0;
        // Every way in use ages first; the victim is chosen on the aged values,
        // so ways that both saturate tie and the lower index goes.
        row_new = row;
        for (int w = 0; w < MAX_WAYS; w++)
            if (w < int'(ways_reg) && row[w].age != AGE_MAX)
                row_new[w].age = row[w].age + AGE_W'(1);
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (w < int'(ways_reg))
            begin
                if (!hit && row[w].valid && row[w].tag == tag_reg)
                begin
                    hit   = 1'b1;
                    hit_w = WAY_W'(w);
                end
                if (!inv_found && !row[w].valid)
                begin
                    inv_found = 1'b1;
                    inv_w     = WAY_W'(w);
                end
                if (row_new[w].age > row_new[old_w].age)
                    old_w = WAY_W'(w);
            end
        end
        vic_w = inv_found ? inv_w : old_w;
        if (hit)
        begin
            mref = MREF_HIT;
            row_new[hit_w].age = '0;
            if (wr_reg)
                row_new[hit_w].dirty = 1'b1;
        end
        else
        begin
            mref = (!inv_found && row[vic_w].dirty) ? MREF_WBACK : MREF_FILL;
            row_new[vic_w] = '{valid: 1'b1, tag: tag_reg, dirty: wr_reg, age: '0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            mem[set_reg] <= row_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_ok_reg <= '0;
        else if (cmd.update)
            row_ok_reg[set_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_error       <= bad_reg;
            out_hit         <= !bad_reg && hit;
            out_tag         <= bad_reg ? '0 : tag_reg;
            out_set_index   <= bad_reg ? '0 : SETIDX_W'(set_reg);
            out_line_offset <= bad_reg ? '0 : off_reg;
            out_memrefs     <= bad_reg ? MREF_HIT : mref;
        end
    end

    a_no_update_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !bad_reg)
        else $error("cache written on a bad access");
    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> row_ok_reg[$past(set_reg)])
        else $error("row not marked valid");
    a_hit_no_refs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && hit && !bad_reg |-> mref == MREF_HIT)
        else $error("hit counted a memory transfer");

    logic unused_ok;
    assign unused_ok = ^{ROW_W, tag_c[63:TAG_W], set_c[63:SET_W], off_c[63:OFF_W]};

endmodule
